// File: rtl/iearm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iearm_pkg: shared definitions for the inline ECC address remap tracker
// Sizes, remap constants, tag types and the controller command bundle.
// ----------------------------------------------------------------------------
package iearm_pkg;

  localparam int NUM_BANKS = 16;
  localparam int ENTRIES   = 4;

  localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  // Request and result field widths.
  localparam int IN_BANK_W  = 4;
  localparam int IN_ROW_W   = 16;
  localparam int IN_COL_W   = 10;
  localparam int MROW_W     = 17;
  localparam int MCOL_W     = 11;
  localparam int ATOM_W     = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Remap constants. L / 1792 is taken as ((L / 256) / 7); the division by 7
  // is a multiply by ceil(2^20 / 7), exact for all quotients below 2^20 / 3.
  localparam int Q1_W        = 17;
  localparam int RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP = 18'd149797;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = Q1_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [MCOL_W-1:0] DATA_COLS = 11'd1792;

  typedef struct packed {
    logic [ATOM_W-1:0] atom;
    logic [MROW_W-1:0] row;
  } tag_t;

  typedef tag_t [ENTRIES-1:0] tag_row_t;

  typedef struct packed {
    logic load;    // take the offered request into the operand registers
    logic commit;  // resolve the request into the output register
  } ctrl_cmd_t;

  // Bank index reduced modulo NUM_BANKS, laid out as a small constant table.
  function automatic logic [BANK_W-1:0] bank_sel(input logic [IN_BANK_W-1:0] bank);
    logic [BANK_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << IN_BANK_W); i++) begin
      if (bank == IN_BANK_W'(i)) begin
        r = BANK_W'(i % NUM_BANKS);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/inline_ecc_address_remap_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inline_ecc_address_remap_tracker: inline ECC remap with per-bank tag FIFOs
// Remaps a decoded request around the inline ECC columns and reports
// whether an ECC read must precede the data access.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload (tdata, lowest bit first)
//  -------  ---------  -----------------------------------------------------
//  s_*      in         bank[3:0], row[19:4], column[29:20], zero pad [31:30]
//  m_*      out        mapped_row[16:0], mapped_column[27:17],
//                      ecc_read_needed[28], ecc_column[39:29]
//
// For each request, the accepting edge registers the operands, the
// reciprocal product for the division by 1792 and the bank's tag row
// from the tag memory; the commit edge does the tag compare and FIFO
// update and loads the output register.
// A new request is accepted in the cycle after the result is loaded, even
// while that result still waits to be taken.
// If the output register is still occupied, the request waits in the
// resolve step until the downstream side takes the earlier transfer.
// Reset clears the per-bank fill counts, so every tag reads as invalid; the
// tag memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module inline_ecc_address_remap_tracker import iearm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // bank[3:0], row[19:4], column[29:20], zero pad [31:30]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // mapped_row[16:0], mapped_column[27:17], ecc_read_needed[28],
  // ecc_column[39:29]
  output logic      [OUT_TDATA_W-1:0] m_tdata
);

  ctrl_cmd_t cmd;

  // The sequencer issues load and commit; all payload lives in the datapath.
  iearm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  iearm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule
`default_nettype wire

// File: rtl/iearm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iearm_ctrl: request sequencer
// Takes one request at a time, resolves it once the output register is free
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module iearm_ctrl import iearm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CALC
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);
  assign cmd      = '{load:   in_valid && in_ready,
                      commit: (state == ST_CALC) && (!out_valid || out_ready)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (cmd.commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/iearm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iearm_datapath: remap arithmetic, per-bank tag memory and result register
// Operands and the tag row are registered on load; the remap, tag lookup
// and FIFO update resolve on commit.
// ----------------------------------------------------------------------------
module iearm_datapath import iearm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctrl_cmd_t              cmd,
  input  wire logic [IN_TDATA_W-1:0]  in_data,
  output logic      [OUT_TDATA_W-1:0] out_data
);

  logic [IN_BANK_W-1:0] in_bank;
  logic [IN_ROW_W-1:0]  in_row;
  logic [IN_COL_W-1:0]  in_col;
  logic [Q1_W-1:0]      q1_c;
  logic [PROD_W-1:0]    prod_c;

  logic [BANK_W-1:0]    bank_q;
  logic [IN_ROW_W-1:0]  row_q;
  logic [7:0]           col_lo_q;
  logic [Q1_W-1:0]      q1_q;
  logic [PROD_W-1:0]    prod_q;
  tag_row_t             tag_rd;

  tag_row_t             tag_mem [NUM_BANKS];
  logic [CNT_W-1:0]     fill [NUM_BANKS];

  logic [QUOT_W-1:0]    quot;
  logic [QUOT_W+2:0]    seven_q;
  logic [2:0]           rem;
  logic [MROW_W-1:0]    mrow;
  logic [MCOL_W-1:0]    mcol;
  logic [MCOL_W-1:0]    ecc_col;
  tag_t                 new_tag;
  logic [CNT_W-1:0]     fill_cur;
  logic [CNT_W-1:0]     fill_new;
  logic                 hit;
  tag_row_t             row_next;

  assign in_bank = in_data[IN_BANK_W-1:0];
  assign in_row  = in_data[IN_BANK_W +: IN_ROW_W];
  assign in_col  = in_data[IN_BANK_W+IN_ROW_W +: IN_COL_W];

  // L / 256 is the row plus the two high column bits.
  assign q1_c   = Q1_W'(in_row) + Q1_W'(in_col[9:8]);
  assign prod_c = PROD_W'(q1_c) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bank_q   <= bank_sel(in_bank);
      row_q    <= in_row;
      col_lo_q <= in_col[7:0];
      q1_q     <= q1_c;
      prod_q   <= prod_c;
      tag_rd   <= tag_mem[bank_sel(in_bank)];
    end
  end

  always_comb begin
    quot     = prod_q[PROD_W-1:RECIP_SHIFT];
    seven_q  = {quot, 3'b000} - (QUOT_W+3)'(quot);
    rem      = 3'((QUOT_W+3)'(q1_q) - seven_q);
    mrow     = MROW_W'(quot) + MROW_W'(row_q);
    mcol     = {rem, col_lo_q};
    new_tag  = '{atom: rem[2:1], row: mrow};
    ecc_col  = DATA_COLS + MCOL_W'({rem[2:1], 5'b00000});
    fill_cur = fill[bank_q];

    hit = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if ((CNT_W'(i) < fill_cur) && (tag_rd[i] == new_tag)) begin
        hit = 1'b1;
      end
    end

    row_next = tag_rd;
    if (fill_cur >= CNT_W'(ENTRIES)) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        row_next[i] = tag_rd[i+1];
      end
      row_next[ENTRIES-1] = new_tag;
      fill_new = CNT_W'(ENTRIES);
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (CNT_W'(i) == fill_cur) begin
          row_next[i] = new_tag;
        end
      end
      fill_new = fill_cur + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit) begin
      tag_mem[bank_q] <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        fill[b] <= '0;
      end
    end else if (cmd.commit && !hit) begin
      fill[bank_q] <= fill_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {(hit ? {MCOL_W{1'b0}} : ecc_col), !hit, mcol, mrow};
    end
  end

endmodule
`default_nettype wire

// File: rtl/iearm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iearm_checker: port-level checks for the remap tracker
// Watches the stream ports and flags results that break the remap rules.
// ----------------------------------------------------------------------------
module iearm_checker import iearm_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Requests are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[27:17] < DATA_COLS))
    else $error("mapped column reaches the ECC area");

  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[28] |-> (m_tdata[39:29] == '0))
    else $error("ECC column set on a tag hit");

  a_miss_col: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |-> (m_tdata[39:29] >= DATA_COLS) && (m_tdata[33:29] == '0))
    else $error("ECC column off the ECC grid on a tag miss");

endmodule

bind inline_ecc_address_remap_tracker iearm_checker u_iearm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
